// ----- design/nearest_spot_park_return_controller_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nearest spot park and return controller
// Concurrent checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SPOT_PARK_RETURN_CONTROLLER_CORE_DEFINES_SVH
`define NEAREST_SPOT_PARK_RETURN_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define NSPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication.
`define NSPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define NSPR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define NSPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/nspr_pkg.sv -----
// ----------------------------------------------------------------------------
// nspr_pkg
// Operation, command, status and sequencer codes of the park and return
// controller.
// ----------------------------------------------------------------------------
package nspr_pkg;

   typedef enum logic [2:0] {
      OP_LOAD_SPOT = 3'd0,
      OP_PARK      = 3'd1,
      OP_GO_BACK   = 3'd2,
      OP_STOPPED   = 3'd3,
      OP_POSE      = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CMD_SET_GOAL  = 2'd0,
      CMD_ROTATE    = 2'd1,
      CMD_TURN_DONE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_PARKING   = 2'd0,
      ST_PARKED    = 2'd1,
      ST_RETURNING = 2'd2,
      ST_RETURNED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'b001,
      SEQ_SCAN  = 3'b010,
      SEQ_DRAIN = 3'b100
   } seq_type;

   // Register select, taken from address bit 2.
   localparam logic [0:0] REG_SPOT_COUNT   = 1'd0;
   localparam logic [0:0] REG_HEADING_TOL  = 1'd1;

   localparam logic [6:0]  SPOT_COUNT_RESET = 7'd1;
   localparam logic [12:0] HEADING_TOL_RESET = 13'd410;

endpackage

// ----- design/nearest_spot_park_return_controller_core.sv -----
// ----------------------------------------------------------------------------
// nearest_spot_park_return_controller_core
// Parking spot table with a nearest-spot scan, park and return status
// tracking and heading alignment after return.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the req_ stream: tuser carries the operation, tdata the
// spot index, position, heading and goal-reached flag. Results leave on the
// rsp_ stream: tuser carries the command, tdata goal, rotation, chosen spot
// and status. Loads, stops and pose updates without turning give no word.
// A park word starts a scan of the loaded spots through one distance
// pipeline fed by the spot memory read port, one spot per cycle, with
// spot_count held to 1..MAX_SPOTS. Read data, absolute differences and
// squares are registered in turn before the compare, and the result word
// is registered after the last compare; other results come in the next cycle.
// The output register lets a new word be accepted in the cycle the waiting
// result is taken. While the receiver stalls with a result held, and while
// a scan runs, req_tready is low.
// Reset puts the status to returned, clears turning, pose and return pose,
// and loads the register defaults. The spot table is not cleared; a scan
// must only cover entries that were loaded. The user must write registers
// on the csr_ port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "nearest_spot_park_return_controller_core_defines.svh"

module nearest_spot_park_return_controller_core #(
   parameter int MAX_SPOTS  = 64,
   parameter int COORD_BITS = 24,
   localparam int REQ_W = ((2 * COORD_BITS + 22 + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 24 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // Request stream
   input  logic             req_tvalid,
   output logic             req_tready,
   // tdata, lowest bit up: spot_index, pos_x, pos_y, heading, goal_reached
   input  logic [REQ_W-1:0] req_tdata,
   // tuser: operation
   input  logic [2:0]       req_tuser,
   // Response stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tdata, lowest bit up: goal_x, goal_y, rotate_by, chosen_spot, status_now
   output logic [RSP_W-1:0] rsp_tdata,
   // tuser: command
   output logic [1:0]       rsp_tuser,
   // Register port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import nspr_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int AW = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
   localparam int IW = (AW > 6) ? AW : 6;

   // Request fields
   logic [5:0]    req_idx;
   logic [C-1:0]  req_px;
   logic [C-1:0]  req_py;
   logic [14:0]   req_hd;
   logic          req_reached;
   op_type        req_op;
   logic          req_fire;

   // Control and architectural state
   seq_type       state_ff, state_in;
   status_type    status_ff, status_in;
   logic          turning_ff, turning_in;
   logic [6:0]    spot_count_ff, spot_count_in;
   logic [12:0]   tol_ff, tol_in;
   logic [C-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [14:0]   cur_hd_ff, cur_hd_in;
   logic [C-1:0]  ret_x_ff, ret_x_in, ret_y_ff, ret_y_in;
   logic [14:0]   ret_hd_ff, ret_hd_in;
   logic [AW-1:0] scan_idx_ff, scan_idx_in, scan_last_ff, scan_last_in;

   // Spot memory
   logic [2*C-1:0] spot_mem [MAX_SPOTS];
   logic           mem_we;
   logic [IW-1:0]  widx_ext;
   logic [AW-1:0]  mem_waddr;
   logic [2*C-1:0] rd_data_ff;

   // Distance pipeline
   logic           rd_valid_ff, rd_valid_in, rd_last_ff, rd_last_in;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic           ad_valid_ff, ad_valid_in, ad_last_ff, ad_last_in;
   logic [AW-1:0]  ad_idx_ff, ad_idx_in;
   logic [C-1:0]   ad_x_ff, ad_x_in, ad_y_ff, ad_y_in;
   logic [C-1:0]   ad_sx_ff, ad_sx_in, ad_sy_ff, ad_sy_in;
   logic           sq_valid_ff, sq_valid_in, sq_last_ff, sq_last_in;
   logic [AW-1:0]  sq_idx_ff, sq_idx_in;
   logic [2*C-1:0] sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [C-1:0]   sq_sx_ff, sq_sx_in, sq_sy_ff, sq_sy_in;
   logic [2*C:0]   best_dist_ff, best_dist_in;
   logic [AW-1:0]  best_idx_ff, best_idx_in;
   logic [C-1:0]   best_x_ff, best_x_in, best_y_ff, best_y_in;

   logic [C:0]     dx, dy, mag_x, mag_y;
   logic [C-1:0]   rd_sx, rd_sy;
   logic [2*C:0]   dist_sum;
   logic           better;
   logic [AW-1:0]  fin_idx;
   logic [C-1:0]   fin_x, fin_y;
   logic [IW-1:0]  fin_idx_ext;

   // Heading error
   logic [15:0]    hd_err, hd_rot, hd_abs;
   logic [31:0]    cnt32, n32;

   // Output register
   logic           rsp_valid_ff, rsp_valid_in;
   cmd_type        rsp_cmd_ff, rsp_cmd_in;
   logic [C-1:0]   rsp_gx_ff, rsp_gx_in, rsp_gy_ff, rsp_gy_in;
   logic [15:0]    rsp_rot_ff, rsp_rot_in;
   logic [5:0]     rsp_spot_ff, rsp_spot_in;
   status_type     rsp_status_ff, rsp_status_in;

   logic           csr_wr;

   assign req_idx     = req_tdata[5:0];
   assign req_px      = req_tdata[6 +: C];
   assign req_py      = req_tdata[6 + C +: C];
   assign req_hd      = req_tdata[6 + 2 * C +: 15];
   assign req_reached = req_tdata[21 + 2 * C];
   assign req_op      = op_type'(req_tuser);

   assign req_tready = (state_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cmd_ff;
   assign rsp_tdata  = RSP_W'({rsp_status_ff, rsp_spot_ff, rsp_rot_ff, rsp_gy_ff, rsp_gx_ff});

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_SPOT_COUNT:  csr_prdata = {25'd0, spot_count_ff};
         REG_HEADING_TOL: csr_prdata = {19'd0, tol_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Spot count clamped to 1..MAX_SPOTS gives the last scanned index.
   always_comb begin
      cnt32 = 32'(spot_count_ff);
      if (cnt32 == 32'd0) begin
         n32 = 32'd1;
      end else if (cnt32 > 32'(MAX_SPOTS)) begin
         n32 = 32'(MAX_SPOTS);
      end else begin
         n32 = cnt32;
      end
   end

   assign widx_ext  = IW'(req_idx);
   assign mem_waddr = widx_ext[AW-1:0];

   assign hd_err = {req_hd[14], req_hd} - {ret_hd_ff[14], ret_hd_ff};
   assign hd_rot = {ret_hd_ff[14], ret_hd_ff} - {req_hd[14], req_hd};
   assign hd_abs = hd_err[15] ? hd_rot : hd_err;

   // Distance pipeline datapath
   assign rd_sx = rd_data_ff[C-1:0];
   assign rd_sy = rd_data_ff[2*C-1:C];
   assign dx    = {cur_x_ff[C-1], cur_x_ff} - {rd_sx[C-1], rd_sx};
   assign dy    = {cur_y_ff[C-1], cur_y_ff} - {rd_sy[C-1], rd_sy};
   assign mag_x = dx[C] ? (~dx + 1'b1) : dx;
   assign mag_y = dy[C] ? (~dy + 1'b1) : dy;

   assign dist_sum    = (2*C+1)'(sq_x_ff) + (2*C+1)'(sq_y_ff);
   // Strict compare keeps the first of equal minima.
   assign better      = (sq_idx_ff == '0) || (dist_sum < best_dist_ff);
   assign fin_idx     = better ? sq_idx_ff : best_idx_ff;
   assign fin_x       = better ? sq_sx_ff : best_x_ff;
   assign fin_y       = better ? sq_sy_ff : best_y_ff;
   assign fin_idx_ext = IW'(fin_idx);

   always_comb begin
      rd_valid_in = (state_ff == SEQ_SCAN);
      rd_last_in  = (scan_idx_ff == scan_last_ff);
      rd_idx_in   = scan_idx_ff;
      ad_valid_in = rd_valid_ff;
      ad_last_in  = rd_last_ff;
      ad_idx_in   = rd_idx_ff;
      ad_x_in     = mag_x[C-1:0];
      ad_y_in     = mag_y[C-1:0];
      ad_sx_in    = rd_sx;
      ad_sy_in    = rd_sy;
      sq_valid_in = ad_valid_ff;
      sq_last_in  = ad_last_ff;
      sq_idx_in   = ad_idx_ff;
      sq_x_in     = (2*C)'(ad_x_ff) * (2*C)'(ad_x_ff);
      sq_y_in     = (2*C)'(ad_y_ff) * (2*C)'(ad_y_ff);
      sq_sx_in    = ad_sx_ff;
      sq_sy_in    = ad_sy_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      if (sq_valid_ff && better) begin
         best_dist_in = dist_sum;
         best_idx_in  = sq_idx_ff;
         best_x_in    = sq_sx_ff;
         best_y_in    = sq_sy_ff;
      end
   end

   // Sequencer and command handling
   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      turning_in    = turning_ff;
      spot_count_in = spot_count_ff;
      tol_in        = tol_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_hd_in     = cur_hd_ff;
      ret_x_in      = ret_x_ff;
      ret_y_in      = ret_y_ff;
      ret_hd_in     = ret_hd_ff;
      scan_idx_in   = scan_idx_ff;
      scan_last_in  = scan_last_ff;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_gx_in     = rsp_gx_ff;
      rsp_gy_in     = rsp_gy_ff;
      rsp_rot_in    = rsp_rot_ff;
      rsp_spot_in   = rsp_spot_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_wr) begin
         case (csr_paddr[2])
            REG_SPOT_COUNT:  spot_count_in = csr_pwdata[6:0];
            REG_HEADING_TOL: tol_in = csr_pwdata[12:0];
            default:         spot_count_in = spot_count_ff;
         endcase
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_LOAD_SPOT: begin
                     mem_we = (32'(req_idx) < 32'(MAX_SPOTS));
                  end
                  OP_PARK: begin
                     if (status_ff == ST_RETURNED) begin
                        ret_x_in  = cur_x_ff;
                        ret_y_in  = cur_y_ff;
                        ret_hd_in = cur_hd_ff;
                     end
                     status_in    = ST_PARKING;
                     scan_idx_in  = '0;
                     scan_last_in = AW'(n32 - 32'd1);
                     state_in     = SEQ_SCAN;
                  end
                  OP_GO_BACK: begin
                     status_in     = ST_RETURNING;
                     rsp_valid_in  = 1'b1;
                     rsp_cmd_in    = CMD_SET_GOAL;
                     rsp_gx_in     = ret_x_ff;
                     rsp_gy_in     = ret_y_ff;
                     rsp_rot_in    = 16'd0;
                     rsp_spot_in   = 6'd0;
                     rsp_status_in = ST_RETURNING;
                  end
                  OP_STOPPED: begin
                     if (req_reached && status_ff == ST_PARKING) begin
                        status_in = ST_PARKED;
                     end else if (req_reached && status_ff == ST_RETURNING) begin
                        status_in  = ST_RETURNED;
                        turning_in = 1'b1;
                     end
                  end
                  OP_POSE: begin
                     cur_x_in  = req_px;
                     cur_y_in  = req_py;
                     cur_hd_in = req_hd;
                     if (turning_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_gx_in     = '0;
                        rsp_gy_in     = '0;
                        rsp_spot_in   = 6'd0;
                        rsp_status_in = status_ff;
                        if (hd_abs < {3'd0, tol_ff}) begin
                           turning_in = 1'b0;
                           rsp_cmd_in = CMD_TURN_DONE;
                           rsp_rot_in = 16'd0;
                        end else begin
                           rsp_cmd_in = CMD_ROTATE;
                           rsp_rot_in = hd_rot;
                        end
                     end
                  end
                  default: begin
                     state_in = SEQ_IDLE;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            if (scan_idx_ff == scan_last_ff) begin
               state_in = SEQ_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         SEQ_DRAIN: begin
            if (sq_valid_ff && sq_last_ff) begin
               state_in      = SEQ_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_cmd_in    = CMD_SET_GOAL;
               rsp_gx_in     = fin_x;
               rsp_gy_in     = fin_y;
               rsp_rot_in    = 16'd0;
               rsp_spot_in   = fin_idx_ext[5:0];
               rsp_status_in = ST_PARKING;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Spot table: one write port for loads, one registered read port for scans.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         spot_mem[mem_waddr] <= {req_py, req_px};
      end
      rd_data_ff <= spot_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         status_ff     <= ST_RETURNED;
         turning_ff    <= 1'b0;
         spot_count_ff <= SPOT_COUNT_RESET;
         tol_ff        <= HEADING_TOL_RESET;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         cur_hd_ff     <= '0;
         ret_x_ff      <= '0;
         ret_y_ff      <= '0;
         ret_hd_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         ad_valid_ff   <= 1'b0;
         sq_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         turning_ff    <= turning_in;
         spot_count_ff <= spot_count_in;
         tol_ff        <= tol_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         cur_hd_ff     <= cur_hd_in;
         ret_x_ff      <= ret_x_in;
         ret_y_ff      <= ret_y_in;
         ret_hd_ff     <= ret_hd_in;
         rd_valid_ff   <= rd_valid_in;
         ad_valid_ff   <= ad_valid_in;
         sq_valid_ff   <= sq_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      scan_last_ff  <= scan_last_in;
      rd_last_ff    <= rd_last_in;
      rd_idx_ff     <= rd_idx_in;
      ad_last_ff    <= ad_last_in;
      ad_idx_ff     <= ad_idx_in;
      ad_x_ff       <= ad_x_in;
      ad_y_ff       <= ad_y_in;
      ad_sx_ff      <= ad_sx_in;
      ad_sy_ff      <= ad_sy_in;
      sq_last_ff    <= sq_last_in;
      sq_idx_ff     <= sq_idx_in;
      sq_x_ff       <= sq_x_in;
      sq_y_ff       <= sq_y_in;
      sq_sx_ff      <= sq_sx_in;
      sq_sy_ff      <= sq_sy_in;
      best_dist_ff  <= best_dist_in;
      best_idx_ff   <= best_idx_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_gx_ff     <= rsp_gx_in;
      rsp_gy_ff     <= rsp_gy_in;
      rsp_rot_ff    <= rsp_rot_in;
      rsp_spot_ff   <= rsp_spot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Checks
   `NSPR_ASSERT_IMPL(a_pipe_only_in_scan, clock, reset, sq_valid_ff, state_ff == SEQ_SCAN || state_ff == SEQ_DRAIN)
   `NSPR_ASSERT_NEXT(a_scan_end_gives_word, clock, reset, sq_valid_ff && sq_last_ff, rsp_valid_ff && rsp_cmd_ff == CMD_SET_GOAL && state_ff == SEQ_IDLE)
   `NSPR_ASSERT_NEXT(a_park_starts_scan, clock, reset, req_fire && req_op == OP_PARK, state_ff == SEQ_SCAN)
   `NSPR_ASSERT_IMPL(a_turn_starts_returned, clock, reset, $rose(turning_ff), status_ff == ST_RETURNED)
   `NSPR_ASSERT_IMPL(a_rotate_while_turning, clock, reset, rsp_valid_ff && rsp_cmd_ff == CMD_ROTATE, turning_ff)

endmodule
